// ----- src/irs_pkg.sv -----
// Shared types and constants for the interlaced row shift block.
// Used by the control, output stage and top modules and by the testbench; depends on nothing else.
`default_nettype none

package irs_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH  = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COL_W      = $clog2(MAX_WIDTH + 1);
    localparam int MEM_DEPTH  = 2 * MAX_WIDTH;

    // Pixel and register widths.
    localparam int COMP_W     = 16;
    localparam int PIX_W      = 4 * COMP_W;
    localparam int LW_W       = 13;
    localparam int OFF_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Width used to compare the programmed line width against the maximum.
    localparam int WW     = (COL_W > LW_W) ? COL_W : LW_W;
    // Signed width of the source column computation.
    localparam int SRC_W  = ((COL_W > OFF_W) ? COL_W : OFF_W) + 2;

    // Output queue geometry.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // Fill values for chroma.
    localparam logic [COMP_W-1:0] FILL_HALF_8  = 16'h0080;
    localparam logic [COMP_W-1:0] FILL_HALF_16 = 16'h8000;
    localparam logic [COMP_W-1:0] FILL_ZERO    = 16'h0000;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH   = 3'd0,
        CFG_OFFSET_EVEN  = 3'd1,
        CFG_OFFSET_ODD   = 3'd2,
        CFG_IS_YUV       = 3'd3,
        CFG_HAS_ALPHA    = 3'd4,
        CFG_WIDE_SAMPLES = 3'd5
    } cfg_idx_t;

    // Release request travelling from the control stage to the output stage.
    typedef struct packed {
        logic              valid;
        logic              fill;
        logic [COMP_W-1:0] half;
        logic              alpha_en;
        logic              eor;
    } rel_t;

    // One finished output pixel.
    typedef struct packed {
        logic [COMP_W-1:0] c3;
        logic [COMP_W-1:0] c2;
        logic [COMP_W-1:0] c1;
        logic [COMP_W-1:0] c0;
        logic              eor;
    } opix_t;

endpackage

`default_nettype wire

// ----- src/irs_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; width and depth come from its parameters.
`default_nettype none

module irs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/irs_ctrl.sv -----
// Control stage: configuration registers, row and column tracking, line store
// addressing and release requests. Depends on irs_pkg.
`default_nettype none

module irs_ctrl
    import irs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  accept,
    input  wire logic                  op,
    input  wire logic                  frame_start,
    output logic                       mem_we,
    output logic [ADDR_W:0]            mem_waddr,
    output logic                       mem_re,
    output logic [ADDR_W:0]            mem_raddr,
    output rel_t                       rel_reg
);

    logic [LW_W-1:0]         line_width_reg;
    logic signed [OFF_W-1:0] offset_even_reg;
    logic signed [OFF_W-1:0] offset_odd_reg;
    logic                    is_yuv_reg;
    logic                    has_alpha_reg;
    logic                    wide_samples_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic             odd_reg, odd_next;
    logic             bank_reg, bank_next;
    logic             pend_reg, pend_next;
    logic [COL_W-1:0] dcol_reg, dcol_next;
    rel_t             rel_next;

    logic [WW-1:0]           lw_wide;
    logic [COL_W-1:0]        w;
    logic signed [OFF_W-1:0] off;
    logic signed [SRC_W-1:0] src;
    logic                    in_range;
    logic [COL_W-1:0]        dcol_inc;
    logic [COL_W-1:0]        wcol;
    logic [COL_W-1:0]        col_inc;
    logic                    release_en;
    logic                    odd_base;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LW_W'(1920);
            offset_even_reg  <= '0;
            offset_odd_reg   <= '0;
            is_yuv_reg       <= 1'b0;
            has_alpha_reg    <= 1'b0;
            wide_samples_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LINE_WIDTH:   line_width_reg   <= cfg_data[LW_W-1:0];
                CFG_OFFSET_EVEN:  offset_even_reg  <= $signed(cfg_data[OFF_W-1:0]);
                CFG_OFFSET_ODD:   offset_odd_reg   <= $signed(cfg_data[OFF_W-1:0]);
                CFG_IS_YUV:       is_yuv_reg       <= cfg_data[0];
                CFG_HAS_ALPHA:    has_alpha_reg    <= cfg_data[0];
                CFG_WIDE_SAMPLES: wide_samples_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Effective width: zero acts as one, anything above the maximum is clamped.
    always_comb
    begin
        lw_wide = WW'(line_width_reg);
        if (lw_wide == '0)
        begin
            w = COL_W'(1);
        end
        else if (lw_wide > WW'(MAX_WIDTH))
        begin
            w = COL_W'(MAX_WIDTH);
        end
        else
        begin
            w = COL_W'(lw_wide);
        end
    end

    // Source column of the pending row; that row has the other parity.
    always_comb
    begin
        off      = odd_reg ? offset_even_reg : offset_odd_reg;
        src      = SRC_W'($signed({1'b0, dcol_reg})) - SRC_W'(off);
        in_range = !src[SRC_W-1] && (src[SRC_W-2:0] < (SRC_W-1)'(w));
        dcol_inc = dcol_reg + COL_W'(1);
    end

    // Next state for an accepted request.
    always_comb
    begin
        col_next   = col_reg;
        odd_next   = odd_reg;
        bank_next  = bank_reg;
        pend_next  = pend_reg;
        dcol_next  = dcol_reg;
        release_en = 1'b0;
        mem_we     = 1'b0;
        odd_base   = odd_reg;
        wcol       = '0;
        col_inc    = '0;

        if (accept)
        begin
            if (op)
            begin
                // Drain request: release one pixel of the pending row if any.
                if (pend_reg && (dcol_reg < w))
                begin
                    release_en = 1'b1;
                    dcol_next  = dcol_inc;
                    if (dcol_inc >= w)
                    begin
                        pend_next = 1'b0;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            else
            begin
                // Pixel request: frame start drops the pending row and the partial row first.
                if (frame_start)
                begin
                    odd_base  = 1'b0;
                    pend_next = 1'b0;
                    dcol_next = '0;
                end
                else if (pend_reg)
                begin
                    if (dcol_reg < w)
                    begin
                        release_en = 1'b1;
                        dcol_next  = dcol_inc;
                        if (dcol_inc >= w)
                        begin
                            pend_next = 1'b0;
                        end
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end

                // Store the pixel, clamping the column to the current width.
                if (frame_start)
                begin
                    wcol = '0;
                end
                else if (col_reg >= w)
                begin
                    wcol = w - COL_W'(1);
                end
                else
                begin
                    wcol = col_reg;
                end
                mem_we  = 1'b1;
                col_inc = wcol + COL_W'(1);
                odd_next = odd_base;

                // Row complete: swap banks and make this row pending.
                if (col_inc >= w)
                begin
                    col_next  = '0;
                    bank_next = ~bank_reg;
                    odd_next  = ~odd_base;
                    pend_next = 1'b1;
                    dcol_next = '0;
                end
                else
                begin
                    col_next = col_inc;
                end
            end
        end
    end

    // Store addressing: writes go to the current bank, reads to the other.
    always_comb
    begin
        mem_waddr = {bank_reg, wcol[ADDR_W-1:0]};
        mem_re    = release_en && in_range;
        mem_raddr = {~bank_reg, src[ADDR_W-1:0]};
    end

    // Release request, registered on its way to the output stage.
    always_comb
    begin
        rel_next.valid    = release_en;
        rel_next.fill     = !in_range;
        rel_next.half     = !is_yuv_reg ? FILL_ZERO
                          : (wide_samples_reg ? FILL_HALF_16 : FILL_HALF_8);
        rel_next.alpha_en = has_alpha_reg;
        rel_next.eor      = (dcol_inc >= w);
    end

    // Row state and release request registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            odd_reg  <= 1'b0;
            bank_reg <= 1'b0;
            pend_reg <= 1'b0;
            dcol_reg <= '0;
            rel_reg  <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            odd_reg  <= odd_next;
            bank_reg <= bank_next;
            pend_reg <= pend_next;
            dcol_reg <= dcol_next;
            rel_reg  <= rel_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/irs_outq.sv -----
// Output stage: merges line store read data with fill values and queues
// finished pixels toward the output channel. Depends on irs_pkg.
`default_nettype none

module irs_outq
    import irs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rel_t               rel,
    input  wire logic [PIX_W-1:0]   rd_data,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output opix_t                   out_pix,
    output logic [OUTQ_CW-1:0]      count
);

    opix_t               entries [OUTQ_DEPTH];
    opix_t               pix;
    logic [OUTQ_AW-1:0]  head_reg, head_next;
    logic [OUTQ_AW-1:0]  tail_reg, tail_next;
    logic [OUTQ_CW-1:0]  count_reg, count_next;
    logic                push;
    logic                pop;

    // Form the output pixel from stored data or fill.
    always_comb
    begin
        if (rel.fill)
        begin
            pix.c0 = FILL_ZERO;
            pix.c1 = rel.half;
            pix.c2 = rel.half;
            pix.c3 = FILL_ZERO;
        end
        else
        begin
            pix.c0 = rd_data[COMP_W-1:0];
            pix.c1 = rd_data[2*COMP_W-1:COMP_W];
            pix.c2 = rd_data[3*COMP_W-1:2*COMP_W];
            pix.c3 = rel.alpha_en ? rd_data[4*COMP_W-1:3*COMP_W] : FILL_ZERO;
        end
        pix.eor = rel.eor;
    end

    // Queue pointers.
    always_comb
    begin
        push       = rel.valid;
        pop        = (count_reg != '0) && !out_stall;
        head_next  = pop  ? head_reg + OUTQ_AW'(1) : head_reg;
        tail_next  = push ? tail_reg + OUTQ_AW'(1) : tail_reg;
        count_next = count_reg + OUTQ_CW'(push) - OUTQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[tail_reg] <= pix;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_pix   = entries[head_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire

// ----- src/interlaced_row_shift_core.sv -----
// A release is registered together with its store read, then written into the output queue.
// Throughput: one request per clock unless stalled; one line store write and read per cycle.
// Input stalls only when the four-entry output queue plus the read in flight is full.
// Reset clears row, column, bank and queue state at once and loads register defaults.
// The line store has no reset; after a width increase, reads can reach unwritten entries.
// Top level of the interlaced row shift block; depends on irs_pkg, irs_ram, irs_ctrl, irs_outq.
`default_nettype none

module interlaced_row_shift_core
    import irs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  op,
    input  wire logic                  frame_start,
    input  wire logic [COMP_W-1:0]     in_comp0,
    input  wire logic [COMP_W-1:0]     in_comp1,
    input  wire logic [COMP_W-1:0]     in_comp2,
    input  wire logic [COMP_W-1:0]     in_comp3,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [COMP_W-1:0]          out_comp0,
    output logic [COMP_W-1:0]          out_comp1,
    output logic [COMP_W-1:0]          out_comp2,
    output logic [COMP_W-1:0]          out_comp3,
    output logic                       out_end_of_row
);

    logic               accept;
    logic               mem_we;
    logic [ADDR_W:0]    mem_waddr;
    logic               mem_re;
    logic [ADDR_W:0]    mem_raddr;
    logic [PIX_W-1:0]   rd_data;
    rel_t               rel;
    opix_t              out_pix;
    logic [OUTQ_CW-1:0] q_count;

    // Registers are always writable.
    assign cfg_ready = 1'b1;

    // Hold requests when the queue could not take the read in flight and one more.
    assign in_stall = ((OUTQ_CW + 1)'(q_count) + (OUTQ_CW + 1)'(rel.valid))
                      >= (OUTQ_CW + 1)'(OUTQ_DEPTH);
    assign accept   = in_valid && !in_stall;

    irs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .op          (op),
        .frame_start (frame_start),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .rel_reg     (rel)
    );

    irs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MEM_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata ({in_comp3, in_comp2, in_comp1, in_comp0}),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    irs_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .rel       (rel),
        .rd_data   (rd_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_pix   (out_pix),
        .count     (q_count)
    );

    assign out_comp0      = out_pix.c0;
    assign out_comp1      = out_pix.c1;
    assign out_comp2      = out_pix.c2;
    assign out_comp3      = out_pix.c3;
    assign out_end_of_row = out_pix.eor;

`ifndef SYNTHESIS
    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n) q_count <= OUTQ_CW'(OUTQ_DEPTH))
        else $error("output queue overflow");

    // A release arriving at the queue always finds a free entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        rel.valid |-> (q_count < OUTQ_CW'(OUTQ_DEPTH)))
        else $error("release pushed into a full queue");

    // Reads and writes of the line store always target different banks.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr[ADDR_W] != mem_raddr[ADDR_W]))
        else $error("line store read and write hit the same bank");

    // A store read is only issued for a request accepted in that cycle.
    assert property (@(posedge clk) disable iff (!rst_n) mem_re |-> accept)
        else $error("line store read without an accepted request");
`endif

endmodule

`default_nettype wire

// ----- dv/irs_row_shift_tracker_pkg.sv -----
`timescale 1ns / 100ps
// Expected-pixel tracker for the interlaced row shift testbench: a cycle-free
// prediction of the line store, row parity and release column. Depends on irs_pkg.

package irs_row_shift_tracker_pkg;

    import irs_pkg::*;

    class row_shift_tracker;

        // Mirror of the ping-pong line store and the row bookkeeping.
        logic [PIX_W-1:0] line_mem [MEM_DEPTH];
        int               write_col;
        int               release_col;
        bit               odd_row;
        bit               write_bank;
        bit               row_waiting;

        // Mirror of the configuration registers.
        logic [LW_W-1:0]  width_reg;
        int               even_shift;
        int               odd_shift;
        bit               yuv_fill;
        bit               alpha_on;
        bit               wide_fill;

        // Shifted pixels that the block still owes, oldest first.
        opix_t            shifted_pixels_due [$];
        int               mismatches;

        function new();
            write_col   = 0;
            release_col = 0;
            odd_row     = 1'b0;
            write_bank  = 1'b0;
            row_waiting = 1'b0;
            width_reg   = LW_W'(1920);
            even_shift  = 0;
            odd_shift   = 0;
            yuv_fill    = 1'b0;
            alpha_on    = 1'b0;
            wide_fill   = 1'b0;
            mismatches  = 0;
        endfunction

        // A width of zero behaves as one, anything past the store as the store size.
        function int eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return width_reg;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LINE_WIDTH:   width_reg  = data[LW_W-1:0];
                CFG_OFFSET_EVEN:  even_shift = $signed(data[OFF_W-1:0]);
                CFG_OFFSET_ODD:   odd_shift  = $signed(data[OFF_W-1:0]);
                CFG_IS_YUV:       yuv_fill   = data[0];
                CFG_HAS_ALPHA:    alpha_on   = data[0];
                CFG_WIDE_SAMPLES: wide_fill  = data[0];
                default: ;
            endcase
        endfunction

        // Release the next column of the completed row that waits in the other bank.
        function void release_pixel();
            int                w;
            int                shift;
            int                src;
            logic [PIX_W-1:0]  entry;
            logic [COMP_W-1:0] half;
            opix_t             px;
            w = eff_width();
            // The waiting row has the parity opposite to the row being written.
            shift = odd_row ? even_shift : odd_shift;
            src   = release_col - shift;
            half  = !yuv_fill ? FILL_ZERO : (wide_fill ? FILL_HALF_16 : FILL_HALF_8);
            if (src >= 0 && src < w)
            begin
                entry = line_mem[(write_bank ? 0 : MAX_WIDTH) + src];
                px.c0 = entry[15:0];
                px.c1 = entry[31:16];
                px.c2 = entry[47:32];
                px.c3 = entry[63:48];
            end
            else
            begin
                px.c0 = FILL_ZERO;
                px.c1 = half;
                px.c2 = half;
                px.c3 = FILL_ZERO;
            end
            if (!alpha_on)
                px.c3 = FILL_ZERO;
            px.eor = (release_col + 1 >= w);
            shifted_pixels_due.push_back(px);
            release_col++;
            if (release_col >= w)
                row_waiting = 1'b0;
        endfunction

        // Account for one accepted request: a pixel or a drain.
        function void take_request(bit drain, bit new_frame, logic [COMP_W-1:0] c0,
                                   logic [COMP_W-1:0] c1, logic [COMP_W-1:0] c2,
                                   logic [COMP_W-1:0] c3);
            int w;
            w = eff_width();
            if (drain)
            begin
                if (row_waiting && release_col < w)
                    release_pixel();
                else
                    row_waiting = 1'b0;
                return;
            end
            // A new frame drops the waiting row and any partial row.
            if (new_frame)
            begin
                write_col   = 0;
                odd_row     = 1'b0;
                row_waiting = 1'b0;
                release_col = 0;
            end
            if (row_waiting)
            begin
                if (release_col < w)
                    release_pixel();
                else
                    row_waiting = 1'b0;
            end
            // A width lowered mid-row pins the write column to the last one.
            if (write_col >= w)
                write_col = w - 1;
            line_mem[(write_bank ? MAX_WIDTH : 0) + write_col] = {c3, c2, c1, c0};
            write_col++;
            if (write_col >= w)
            begin
                write_col   = 0;
                write_bank  = !write_bank;
                odd_row     = !odd_row;
                row_waiting = 1'b1;
                release_col = 0;
            end
        endfunction

        function int outstanding();
            return shifted_pixels_due.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 200)
                $display("%0t: mismatch: %s", $time, msg);
        endtask

        task compare_pixel(opix_t got);
            opix_t want;
            if (shifted_pixels_due.size() == 0)
            begin
                report_mismatch($sformatf("output pixel %h arrived with none owed", got));
                return;
            end
            want = shifted_pixels_due.pop_front();
            if (got.c0 !== want.c0)
                report_mismatch($sformatf("out_comp0 %h, expected %h", got.c0, want.c0));
            if (got.c1 !== want.c1)
                report_mismatch($sformatf("out_comp1 %h, expected %h", got.c1, want.c1));
            if (got.c2 !== want.c2)
                report_mismatch($sformatf("out_comp2 %h, expected %h", got.c2, want.c2));
            if (got.c3 !== want.c3)
                report_mismatch($sformatf("out_comp3 %h, expected %h", got.c3, want.c3));
            if (got.eor !== want.eor)
                report_mismatch($sformatf("out_end_of_row %b, expected %b", got.eor, want.eor));
        endtask

    endclass

endpackage

// ----- dv/interlaced_row_shift_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for interlaced_row_shift_core: directed rows, an oversized width setting and
// randomized frames under sender and receiver stalls. Depends on irs_pkg and the tracker package.

module interlaced_row_shift_core_tb;

    import irs_pkg::*;
    import irs_row_shift_tracker_pkg::*;

    localparam int CYCLE_LIMIT = 60000;
    localparam int LAT_SLACK   = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  op;
    logic                  frame_start;
    logic [COMP_W-1:0]     in_comp0;
    logic [COMP_W-1:0]     in_comp1;
    logic [COMP_W-1:0]     in_comp2;
    logic [COMP_W-1:0]     in_comp3;
    logic                  out_valid;
    logic                  out_stall;
    logic [COMP_W-1:0]     out_comp0;
    logic [COMP_W-1:0]     out_comp1;
    logic [COMP_W-1:0]     out_comp2;
    logic [COMP_W-1:0]     out_comp3;
    logic                  out_end_of_row;

    row_shift_tracker tracker;
    opix_t            seen_pixel;
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               hold_left   = 0;
    int               cycle_count = 0;
    bit               force_frame = 1'b0;

    interlaced_row_shift_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .frame_start    (frame_start),
        .in_comp0       (in_comp0),
        .in_comp1       (in_comp1),
        .in_comp2       (in_comp2),
        .in_comp3       (in_comp3),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_comp0      (out_comp0),
        .out_comp1      (out_comp1),
        .out_comp2      (out_comp2),
        .out_comp3      (out_comp3),
        .out_end_of_row (out_end_of_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver back-pressure: a long hold-off when requested, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Every accepted output pixel is checked against the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_pixel.c0  = out_comp0;
            seen_pixel.c1  = out_comp1;
            seen_pixel.c2  = out_comp2;
            seen_pixel.c3  = out_comp3;
            seen_pixel.eor = out_end_of_row;
            tracker.compare_pixel(seen_pixel);
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("interlaced_row_shift_core verification failed");
        $finish;
    end

    function automatic logic [COMP_W-1:0] random_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return COMP_W'($urandom);
        endcase
    endfunction

    // Mostly shifts near the row width, sometimes the extremes or anywhere in range.
    function automatic int random_shift(int w);
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return int'($urandom_range(8192)) - 4096;
        if (pick < 16)
            return pick[0] ? 4096 : -4096;
        return int'($urandom_range(2 * w + 2)) - (w + 1);
    endfunction

    // Offer one request, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_request(bit drain, bit new_frame, logic [COMP_W-1:0] s0,
                                logic [COMP_W-1:0] s1, logic [COMP_W-1:0] s2,
                                logic [COMP_W-1:0] s3);
        // After a wider row is set, the old rows are not safe to read: restart the frame.
        if (force_frame)
        begin
            drain       = 1'b0;
            new_frame   = 1'b1;
            force_frame = 1'b0;
        end
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid    <= 1'b1;
        op          <= drain;
        frame_start <= new_frame;
        in_comp0    <= s0;
        in_comp1    <= s1;
        in_comp2    <= s2;
        in_comp3    <= s3;
        do @(posedge clk); while (in_stall);
        tracker.take_request(drain, new_frame, s0, s1, s2, s3);
    endtask

    task automatic pixel_run(int count, bit first_frame);
        int k;
        for (k = 0; k < count; k++)
            send_request(1'b0, first_frame && k == 0, random_sample(), random_sample(),
                         random_sample(), random_sample());
    endtask

    task automatic drain_run(int count);
        int k;
        for (k = 0; k < count; k++)
            send_request(1'b1, $urandom_range(1), random_sample(), random_sample(),
                         random_sample(), random_sample());
    endtask

    // Stop offering and let every owed pixel out, then give the pipeline time to settle.
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (LAT_SLACK) @(posedge clk);
    endtask

    // Write all six registers back to back once the block is idle.
    task automatic write_config(int width_val, int even_val, int odd_val, bit yuv_val,
                                bit alpha_val, bit wide_val);
        cfg_idx_t              regs [6];
        logic [CFG_DATA_W-1:0] vals [6];
        int                    prior_width;
        int                    i;
        wait_results_done();
        prior_width = tracker.eff_width();
        regs = '{CFG_LINE_WIDTH, CFG_OFFSET_EVEN, CFG_OFFSET_ODD,
                 CFG_IS_YUV, CFG_HAS_ALPHA, CFG_WIDE_SAMPLES};
        vals = '{CFG_DATA_W'(width_val), CFG_DATA_W'(even_val), CFG_DATA_W'(odd_val),
                 CFG_DATA_W'(yuv_val), CFG_DATA_W'(alpha_val), CFG_DATA_W'(wide_val)};
        for (i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            tracker.set_reg(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
        if (tracker.eff_width() > prior_width)
            force_frame = 1'b1;
    endtask

    // One random setting followed by frames of mostly pixels, some drains and restarts.
    task automatic random_phase(int item_count, bit midway_pause, int hold_cycles);
        int width_val;
        int w;
        int pick;
        int k;
        pick = $urandom_range(99);
        if (pick < 5)
            width_val = 0;
        else if (pick < 10)
            width_val = 1;
        else if (pick < 85)
            width_val = $urandom_range(2, 12);
        else
            width_val = $urandom_range(13, 64);
        w = (width_val == 0) ? 1 : width_val;
        write_config(width_val, random_shift(w), random_shift(w), $urandom_range(1),
                     $urandom_range(1), $urandom_range(1));
        if (hold_cycles > 0)
            hold_left <= hold_cycles;
        for (k = 0; k < item_count; k++)
        begin
            if (midway_pause && k == item_count / 2)
                wait_results_done();
            pick = $urandom_range(99);
            if (pick < 88)
                pixel_run(1, pick < 3);
            else
                drain_run(1);
        end
        // Empty the last complete row.
        drain_run(w + 2);
    endtask

    initial
    begin
        int mode;
        int ph;
        tracker      = new();
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_LINE_WIDTH;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        op          <= 1'b0;
        frame_start <= 1'b0;
        in_comp0    <= '0;
        in_comp1    <= '0;
        in_comp2    <= '0;
        in_comp3    <= '0;
        out_stall   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Three-pixel rows shifted apart, YUV 8-bit fill with alpha, extreme samples.
        write_config(3, 1, -1, 1'b1, 1'b1, 1'b0);
        send_request(1'b0, 1'b1, '1, '1, '1, '1);
        send_request(1'b0, 1'b0, '0, '0, '0, '0);
        send_request(1'b0, 1'b0, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0);
        pixel_run(3, 1'b0);
        drain_run(4);

        // Zero width acts as one; extreme shifts turn every row into 16-bit fill.
        write_config(0, 4096, -4096, 1'b1, 1'b0, 1'b1);
        pixel_run(3, 1'b1);
        drain_run(2);

        // Width lowered in the middle of a row: write column pinned, old row dropped.
        write_config(4, 1, -1, 1'b0, 1'b1, 1'b0);
        pixel_run(7, 1'b1);
        write_config(2, 1, -1, 1'b0, 1'b1, 1'b0);
        pixel_run(1, 1'b0);
        drain_run(2);

        // Random frames: sender-light, receiver-light, then no idling at all.
        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    tx_idle_pct  = 12;
                    rx_idle_pct <= 65;
                end
                1:
                begin
                    tx_idle_pct  = 65;
                    rx_idle_pct <= 12;
                end
                default:
                begin
                    tx_idle_pct  = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            for (ph = 0; ph < 6; ph++)
                random_phase(85, mode == 1 && ph == 2, (ph == 1 && mode != 1) ? 150 : 0);
        end

        // Oversized width register clamps to the full store, so a short row never completes.
        write_config(8191, -4095, 4095, 1'b1, 1'b1, 1'b1);
        pixel_run(40, 1'b1);
        drain_run(4);

        wait_results_done();
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("interlaced_row_shift_core verification clean");
        else
            $display("interlaced_row_shift_core verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/irs_pkg.sv
src/irs_ram.sv
src/irs_ctrl.sv
src/irs_outq.sv
src/interlaced_row_shift_core.sv
dv/irs_row_shift_tracker_pkg.sv
dv/interlaced_row_shift_core_tb.sv
